// ===== rtl/swin_pkg.sv =====
// Constants, command struct and a helper shared by the send window.
package swin_pkg;

  localparam int unsigned Depth = 8;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  localparam logic [CntW-1:0] FillLimit = CntW'(Depth / 2);

  localparam int unsigned TimerW = 16;
  localparam logic [TimerW-1:0] TimerMax     = '1;
  localparam logic [TimerW-1:0] TimeoutReset = 16'd1000;

  // Request kinds
  localparam logic [2:0] KindEnq  = 3'd0;
  localparam logic [2:0] KindAck  = 3'd1;
  localparam logic [2:0] KindNak  = 3'd2;
  localparam logic [2:0] KindTick = 3'd3;
  localparam logic [2:0] KindFlow = 3'd4;

  // Result kinds
  localparam logic ResStatus = 1'b0;
  localparam logic ResFrame  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic enq;
    logic ack;
    logic nak;
    logic tick;
    logic flow;
    logic step;
    logic flush;
    logic cfg_we;
  } swin_cmd_t;

  // Advance a ring index with wrap
  function automatic logic [IdxW-1:0] idx_next(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] nxt;
    nxt = (idx == IdxW'(Depth - 1)) ? '0 : idx + 1'b1;
    return nxt;
  endfunction

endpackage

// ===== rtl/swin_ctrl.sv =====
// Controller state machine: decodes requests and sequences the tick scan.
module swin_ctrl import swin_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [2:0] kind_i,
  input  logic       cfg_valid_i,
  input  logic       scan_done_i,
  output logic       busy,
  output logic       cfg_ready_o,
  output swin_cmd_t  cmd_o
);

  localparam logic [1:0] SIdle  = 2'd0;
  localparam logic [1:0] SScan  = 2'd1;
  localparam logic [1:0] SDrain = 2'd2;
  localparam logic [1:0] SFlush = 2'd3;

  logic [1:0] state_q, state_d;

  // Decode requests and step the scan
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      SIdle: begin
        if (start) begin
          case (kind_i)
            KindEnq:  cmd_o.enq = 1'b1;
            KindAck:  cmd_o.ack = 1'b1;
            KindNak: begin
              cmd_o.nak = 1'b1;
              state_d   = SDrain;
            end
            KindTick: begin
              cmd_o.tick = 1'b1;
              state_d    = SScan;
            end
            KindFlow: cmd_o.flow = 1'b1;
            default: ;
          endcase
        end
      end
      SScan: begin
        if (scan_done_i) begin
          state_d = SDrain;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      SDrain: state_d = SFlush;
      SFlush: begin
        cmd_o.flush = 1'b1;
        state_d     = SIdle;
      end
      default: state_d = SIdle;
    endcase
    cmd_o.cfg_we = cfg_valid_i && (state_q == SIdle);
  end

  assign busy        = (state_q != SIdle);
  assign cfg_ready_o = (state_q == SIdle);

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/swin_dp.sv =====
// Datapath: slot store, window pointers, timers, frame staging and result register.
module swin_dp import swin_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  swin_cmd_t         cmd_i,
  input  logic [7:0]        data_byte_i,
  input  logic [2:0]        seq_i,
  input  logic              pause_i,
  input  logic [TimerW-1:0] cfg_data_i,
  output logic              scan_done_o,
  output logic              result_valid_o,
  output logic              result_kind_o,
  output logic [2:0]        frame_seq_o,
  output logic [7:0]        frame_data_o,
  output logic              accepted_o,
  output logic              is_retry_o,
  output logic              last_of_run_o
);

  logic [7:0]        mem_q [Depth];
  logic [7:0]        rdata_q;
  logic [Depth-1:0]  acked_q, sent_q;
  logic [TimerW-1:0] elapsed_q [Depth];
  logic [IdxW-1:0]   front_q, rear_q, scan_q;
  logic [CntW-1:0]   fill_q;
  logic              paused_q;
  logic [TimerW-1:0] timeout_q;

  logic              found_v_q, found_retry_q;
  logic [IdxW-1:0]   found_seq_q;
  logic              pend_v_q, pend_retry_q;
  logic [IdxW-1:0]   pend_seq_q;
  logic [7:0]        pend_data_q;

  logic              res_v_q, res_kind_q, res_acc_q, res_retry_q, res_last_q;
  logic [IdxW-1:0]   res_seq_q;
  logic [7:0]        res_data_q;

  logic              enq_ok, enq_do, cur_due, cur_slide;
  logic [IdxW-1:0]   rd_addr;

  // Evaluate the slot under the scan pointer
  assign enq_ok      = !paused_q && (fill_q <= FillLimit);
  assign enq_do      = cmd_i.enq && enq_ok;
  assign cur_due     = !acked_q[scan_q] &&
                       (!sent_q[scan_q] || (elapsed_q[scan_q] > timeout_q));
  assign cur_slide   = acked_q[scan_q] && (scan_q == front_q);
  assign scan_done_o = (scan_q == rear_q);
  assign rd_addr     = cmd_i.nak ? seq_i : scan_q;

  // Slot byte store with registered read
  always_ff @(posedge clk_i) begin
    if (enq_do) begin
      mem_q[rear_q] <= data_byte_i;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Update per-slot marks and timers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acked_q <= '0;
      sent_q  <= '0;
      for (int i = 0; i < Depth; i++) begin
        elapsed_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < Depth; i++) begin
        if (enq_do && (rear_q == IdxW'(i))) begin
          acked_q[i]   <= 1'b0;
          sent_q[i]    <= 1'b0;
          elapsed_q[i] <= '0;
        end
        if (cmd_i.ack && (seq_i == IdxW'(i))) begin
          acked_q[i] <= 1'b1;
        end
        if (cmd_i.nak && (seq_i == IdxW'(i))) begin
          sent_q[i]    <= 1'b1;
          elapsed_q[i] <= '0;
        end
        if (cmd_i.tick && sent_q[i] && (elapsed_q[i] != TimerMax)) begin
          elapsed_q[i] <= elapsed_q[i] + 1'b1;
        end
        if (cmd_i.step && (scan_q == IdxW'(i)) && cur_due) begin
          sent_q[i]    <= 1'b1;
          elapsed_q[i] <= '0;
        end
      end
    end
  end

  // Advance window pointers, fill count, pause and timeout
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q   <= '0;
      rear_q    <= '0;
      scan_q    <= '0;
      fill_q    <= '0;
      paused_q  <= 1'b0;
      timeout_q <= TimeoutReset;
    end else begin
      if (enq_do) begin
        rear_q <= idx_next(rear_q);
        fill_q <= fill_q + 1'b1;
      end
      if (cmd_i.tick) begin
        scan_q <= front_q;
      end
      if (cmd_i.step) begin
        scan_q <= idx_next(scan_q);
        if (cur_slide) begin
          front_q <= idx_next(front_q);
          if (fill_q != '0) begin
            fill_q <= fill_q - 1'b1;
          end
        end
      end
      if (cmd_i.flow) begin
        paused_q <= pause_i;
      end
      if (cmd_i.cfg_we) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  // Mark a frame found this cycle; its byte arrives with the read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_v_q <= 1'b0;
    end else begin
      found_v_q <= cmd_i.nak || (cmd_i.step && cur_due);
    end
  end

  always_ff @(posedge clk_i) begin
    found_seq_q   <= cmd_i.nak ? seq_i : scan_q;
    found_retry_q <= cmd_i.nak ? 1'b1 : sent_q[scan_q];
  end

  // Hold one frame back so the final one can carry the last mark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
    end else if (found_v_q) begin
      pend_v_q <= 1'b1;
    end else if (cmd_i.flush) begin
      pend_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (found_v_q) begin
      pend_seq_q   <= found_seq_q;
      pend_data_q  <= rdata_q;
      pend_retry_q <= found_retry_q;
    end
  end

  // Drive the result register for one cycle per result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else begin
      res_v_q <= cmd_i.enq || (pend_v_q && (found_v_q || cmd_i.flush));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.enq) begin
      res_kind_q  <= ResStatus;
      res_seq_q   <= '0;
      res_data_q  <= '0;
      res_acc_q   <= enq_ok;
      res_retry_q <= 1'b0;
      res_last_q  <= 1'b1;
    end else begin
      res_kind_q  <= ResFrame;
      res_seq_q   <= pend_seq_q;
      res_data_q  <= pend_data_q;
      res_acc_q   <= 1'b0;
      res_retry_q <= pend_retry_q;
      res_last_q  <= !found_v_q;
    end
  end

  assign result_valid_o = res_v_q;
  assign result_kind_o  = res_kind_q;
  assign frame_seq_o    = res_seq_q;
  assign frame_data_o   = res_data_q;
  assign accepted_o     = res_acc_q;
  assign is_retry_o     = res_retry_q;
  assign last_of_run_o  = res_last_q;

  // Fill count stays within what the enqueue limit allows
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillLimit + 1'b1)
    else $error("fill count beyond limit");

  // Empty window exactly when the pointers meet
  a_ptr_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_q == rear_q) == (fill_q == '0))
    else $error("pointers and fill count disagree");

  // A found frame is always staged on the next cycle
  a_found_staged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_v_q |=> pend_v_q)
    else $error("found frame not staged");

endmodule

// ===== rtl/selective_repeat_send_window.sv =====
// Enqueue, ack and flow requests leave busy low; an enqueue status strobes on the next cycle.
// A nak raises busy through the drain and flush states; its frame strobes as busy drops.
// A tick raises busy through the scan, drain and flush states, one slot a cycle from front to
// rear through the shared timer compare; each frame strobes as the next is found, and the
// last one, marked, as busy drops. Results cannot be stalled. Reset empties the window, clears
// marks, timers and pause, and loads the timeout with 1000; slot bytes are not cleared.
module selective_repeat_send_window import swin_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        kind_i,
  input  logic [7:0]        data_byte_i,
  input  logic [2:0]        seq_i,
  input  logic              pause_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [TimerW-1:0] cfg_data_i,
  output logic              result_valid_o,
  output logic              result_kind_o,
  output logic [2:0]        frame_seq_o,
  output logic [7:0]        frame_data_o,
  output logic              accepted_o,
  output logic              is_retry_o,
  output logic              last_of_run_o
);

  swin_cmd_t cmd;
  logic      scan_done;

  // Sequence requests
  swin_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .kind_i      (kind_i),
    .cfg_valid_i (cfg_valid_i),
    .scan_done_i (scan_done),
    .busy        (busy),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd)
  );

  // Window state and results
  swin_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .data_byte_i    (data_byte_i),
    .seq_i          (seq_i),
    .pause_i        (pause_i),
    .cfg_data_i     (cfg_data_i),
    .scan_done_o    (scan_done),
    .result_valid_o (result_valid_o),
    .result_kind_o  (result_kind_o),
    .frame_seq_o    (frame_seq_o),
    .frame_data_o   (frame_data_o),
    .accepted_o     (accepted_o),
    .is_retry_o     (is_retry_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule
